// ===== src/sb2d_pkg.sv =====
// Package for the signed binary to decimal ASCII core.
// Holds widths, ASCII codes and the shift-add-3 step function. No dependencies.
package sb2d_pkg;

   localparam int unsigned ValueWidth    = 64;
   localparam int unsigned NumDigits     = 20;
   localparam int unsigned BcdWidth      = 4 * NumDigits;
   localparam int unsigned DdWidth       = BcdWidth + ValueWidth;
   localparam int unsigned StepsPerStage = 8;
   localparam int unsigned NumDdStages   = ValueWidth / StepsPerStage;
   localparam int unsigned PosWidth      = $clog2(NumDigits);
   localparam int unsigned CharWidth     = 6;

   localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
   localparam logic [CharWidth-1:0] AsciiMinus = 6'd45;

   typedef logic [DdWidth-1:0]  dd_type;
   typedef logic [BcdWidth-1:0] bcd_type;
   typedef logic [PosWidth-1:0] pos_type;

   // Eight double-dabble steps: adjust every digit >= 5, then shift left by one.
   function automatic dd_type dd_steps(input dd_type din);
      dd_type d;
      d = din;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int n = 0; n < NumDigits; n++) begin
            if (d[ValueWidth + 4*n +: 4] >= 4'd5) begin
               d[ValueWidth + 4*n +: 4] = d[ValueWidth + 4*n +: 4] + 4'd3;
            end
         end
         d = {d[DdWidth-2:0], 1'b0};
      end
      return d;
   endfunction

endpackage

// ===== src/signed_binary_to_decimal_ascii_core.sv =====
// Signed 64-bit integer to decimal ASCII text, one character per output word.
// Pipeline of 10 stages, followed by the character serializer.
// Throughput: one character per cycle while rsp_ready is high; a number gives 1 to 20
// characters. Pipeline takes a word every cycle when not stalled.
// Reset: synchronous, active high; clears stage valid bits and the serializer busy and sign flags.
// Depends on sb2d_pkg.
module signed_binary_to_decimal_ascii_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [sb2d_pkg::ValueWidth-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sb2d_pkg::CharWidth-1:0]     rsp_character,
   output logic                               rsp_last
);
   import sb2d_pkg::*;

   localparam int unsigned LastStage = NumDdStages + 1; // digit-count stage

   // Pipeline: stage 0 forms magnitude, stages 1..8 run 8 dabble steps each,
   // stage 9 finds the top significant digit.
   logic   v_ff   [0:LastStage];
   logic   v_in   [0:LastStage];
   logic   neg_ff [0:LastStage];
   dd_type dd_ff  [0:NumDdStages];
   logic   take   [0:LastStage];
   bcd_type bcd9_ff;
   pos_type top9_ff;
   pos_type top_in;

   // Serializer registers
   logic    busy_ff, busy_in;
   logic    sign_ff, sign_in;
   pos_type pos_ff, pos_in;
   bcd_type bcd_ff, bcd_in;
   logic    ser_ready;
   logic    rsp_fire;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign ser_ready = !busy_ff || (rsp_fire && rsp_last);

   // Elastic stall chain: a stage loads when empty or when its word moves on.
   always_comb begin
      take[LastStage] = !v_ff[LastStage] || ser_ready;
      for (int i = LastStage - 1; i >= 0; i--) begin
         take[i] = !v_ff[i] || take[i+1];
      end
      v_in[0] = take[0] ? req_valid : v_ff[0];
      for (int i = 1; i <= LastStage; i++) begin
         v_in[i] = take[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign req_ready = take[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LastStage; i++) v_ff[i] <= 1'b0;
      end else begin
         for (int i = 0; i <= LastStage; i++) v_ff[i] <= v_in[i];
      end
   end

   // Highest nonzero digit of the final BCD word (zero gives digit 0).
   always_comb begin
      top_in = '0;
      for (int n = 0; n < NumDigits; n++) begin
         if (dd_ff[NumDdStages][ValueWidth + 4*n +: 4] != 4'd0) top_in = pos_type'(n);
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         neg_ff[0] <= req_value[ValueWidth-1];
         dd_ff[0]  <= {{BcdWidth{1'b0}},
                       req_value[ValueWidth-1] ? (ValueWidth'(0) - req_value) : req_value};
      end
      for (int i = 1; i <= NumDdStages; i++) begin
         if (take[i]) begin
            neg_ff[i] <= neg_ff[i-1];
            dd_ff[i]  <= dd_steps(dd_ff[i-1]);
         end
      end
      if (take[LastStage]) begin
         neg_ff[LastStage] <= neg_ff[NumDdStages];
         bcd9_ff           <= dd_ff[NumDdStages][DdWidth-1:ValueWidth];
         top9_ff           <= top_in;
      end
   end

   // Serializer: sign first, then digits from the top one down to digit 0.
   always_comb begin
      busy_in = busy_ff;
      sign_in = sign_ff;
      pos_in  = pos_ff;
      bcd_in  = bcd_ff;
      if (rsp_fire) begin
         if (sign_ff)               sign_in = 1'b0;
         else if (pos_ff == '0)     busy_in = 1'b0;
         else                       pos_in  = pos_ff - pos_type'(1);
      end
      if (ser_ready && v_ff[LastStage]) begin
         busy_in = 1'b1;
         sign_in = neg_ff[LastStage];
         pos_in  = top9_ff;
         bcd_in  = bcd9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         sign_ff <= sign_in;
      end
      pos_ff <= pos_in;
      bcd_ff <= bcd_in;
   end

   assign rsp_valid     = busy_ff;
   assign rsp_character = sign_ff ? AsciiMinus
                                  : AsciiZero + {2'b00, bcd_ff[4*pos_ff +: 4]};
   assign rsp_last      = !sign_ff && (pos_ff == '0);

endmodule

// ===== test/signed_binary_to_decimal_ascii_checker.sv =====
// Checker for the signed binary to decimal ASCII core: predicts the character
// stream of each accepted value and compares every result word. Uses sb2d_pkg.
module signed_binary_to_decimal_ascii_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [sb2d_pkg::ValueWidth-1:0] req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [sb2d_pkg::CharWidth-1:0]        rsp_character,
   input  logic                                  rsp_last,
   output int                                    fail_count,
   output int                                    pending_chars
);
   timeunit 1ns;
   timeprecision 1ps;
   import sb2d_pkg::*;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } char_word_type;

   char_word_type expected_chars[$];

   // Decimal text of one value, pushed most significant first.
   task automatic queue_decimal_text(input logic signed [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] magnitude;
      logic [3:0]            digit_list[NumDigits];
      int                    num_digits;
      int                    total;
      int                    pos;
      logic                  negative;
      char_word_type         w;
      negative = value[ValueWidth-1];
      // unsigned negate keeps the most negative value exact
      magnitude = negative ? (64'd0 - value) : value;
      num_digits = 0;
      do begin
         digit_list[num_digits] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         num_digits++;
      end while (magnitude != 0 && num_digits < NumDigits);
      total = num_digits + (negative ? 1 : 0);
      pos = 0;
      if (negative) begin
         w.character = AsciiMinus;
         w.last = (pos == total - 1);
         expected_chars.push_back(w);
         pos++;
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
         w.character = AsciiZero + digit_list[i];
         w.last = (pos == total - 1);
         expected_chars.push_back(w);
         pos++;
      end
   endtask

   always @(posedge clock) begin
      char_word_type want;
      if (reset) begin
         fail_count    <= 0;
         pending_chars <= 0;
      end else begin
         if (req_valid && req_ready) queue_decimal_text(req_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected word: character %0d last %0d", rsp_character, rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (want.character !== rsp_character || want.last !== rsp_last) begin
                  if (want.character !== rsp_character)
                     $error("character: expected %0d, actual %0d", want.character, rsp_character);
                  if (want.last !== rsp_last)
                     $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_chars <= expected_chars.size();
      end
   end

endmodule

// ===== test/signed_binary_to_decimal_ascii_core_tb.sv =====
// Testbench top for signed_binary_to_decimal_ascii_core: clock, reset, stimulus
// and verdict. Depends on sb2d_pkg and signed_binary_to_decimal_ascii_checker.
module signed_binary_to_decimal_ascii_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sb2d_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 40;   // extra wait after the drain, before the verdict

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [ValueWidth-1:0]  req_value;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [CharWidth-1:0]          rsp_character;
   logic                          rsp_last;
   int                            fail_count;
   int                            pending_chars;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   int                            quiet_cycles;

   signed_binary_to_decimal_ascii_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_character(rsp_character), .rsp_last(rsp_last)
   );

   signed_binary_to_decimal_ascii_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_character(rsp_character), .rsp_last(rsp_last),
      .fail_count(fail_count), .pending_chars(pending_chars)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stalls at random, changed on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offers one word, with random idle cycles before it; returns at the falling
   // edge after acceptance with valid still high, so the next call or a drain
   // wait decides whether it drops.
   task automatic send_value(input logic [ValueWidth-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Random value with a random magnitude so every character count shows up.
   function automatic logic [ValueWidth-1:0] random_value();
      logic [ValueWidth-1:0] v;
      int                    keep;
      v = {$urandom, $urandom};
      keep = $urandom_range(64, 1);
      if (keep < 64) v = v & ((64'd1 << keep) - 1);
      if ($urandom_range(1)) v = 64'd0 - v;
      return v;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
   endtask

   initial begin
      logic [ValueWidth-1:0] directed[$];
      send_idle_pct = 7;
      recv_idle_pct = 54;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, sign edges, digit-count boundaries.
      directed = '{64'd0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'd1, -64'sd1, 64'd9, 64'd10, -64'sd9, -64'sd10, 64'd99, 64'd100,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'd1000000000000000000,
                   64'd999999999999999999, 64'd10000000000000000000,
                   -64'sd1000000000000000000, 64'h8000_0000_0000_0001, 64'd1234567890};
      foreach (directed[i]) send_value(directed[i]);

      // Hold off until every expected word is back, then random phases.
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 7 : 0;
         for (int n = 0; n < 80; n++) send_value(random_value());
         if (phase == 0) wait_drained();
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
